// File: rtl/string_literal_escape_decoder_assert.svh
// Assertion macros used by the top level of the string literal escape decoder.
`ifndef STRING_LITERAL_ESCAPE_DECODER_ASSERT_SVH
`define STRING_LITERAL_ESCAPE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SLED_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define SLED_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define SLED_ASSERT_IMP(label, clk, rst_n, cond, prop, msg)
`define SLED_ASSERT_NXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// File: rtl/sled_pkg.sv
// Types, error codes and digit helpers for the string literal escape decoder.
package sled_pkg;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_BAD_OCT = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN = 3'd3;
    localparam logic [2:0] ERR_OPEN    = 3'd4;

    // One accepted input word.
    typedef struct packed {
        logic [7:0] ch;
        logic       close_literal;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       last;
        logic [2:0] error_code;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    function automatic t_digit oct_digit(input logic [7:0] ch);
        t_digit d;
        d.ok  = (ch >= "0") && (ch <= "7");
        d.val = {1'b0, ch[2:0]};
        return d;
    endfunction

    // Letters a-f and A-F share their low nibble (1..6), so adding nine gives 10..15.
    function automatic t_digit hex_digit(input logic [7:0] ch);
        t_digit d;
        d.ok  = 1'b0;
        d.val = ch[3:0];
        if ((ch >= "0") && (ch <= "9")) begin
            d.ok = 1'b1;
        end else if (((ch >= "a") && (ch <= "f")) || ((ch >= "A") && (ch <= "F"))) begin
            d.ok  = 1'b1;
            d.val = ch[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

// File: rtl/sled_in_stage.sv
// Input register of the string literal escape decoder.
module sled_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sled_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output sled_pkg::t_item o_item
);
    import sled_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The held word leaves whenever the next stage can take it.
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/sled_core.sv
// Escape decoding state machine of the string literal escape decoder.
module sled_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  sled_pkg::t_item  i_item,
    output logic             o_res_valid,
    output sled_pkg::t_result o_res
);
    import sled_pkg::*;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_ESC    = 3'd1,
        M_OCT1   = 3'd2,
        M_OCT2   = 3'd3,
        M_HEX1   = 3'd4,
        M_HEX2   = 3'd5,
        M_DEAD   = 3'd6
    } t_mode;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [3:0] r_digit;
    logic [3:0] n_digit;
    t_digit     oct_d;
    t_digit     hex_d;

    assign oct_d = oct_digit(i_item.ch);
    assign hex_d = hex_digit(i_item.ch);

    always_comb begin
        n_mode      = r_mode;
        n_digit     = r_digit;
        o_res_valid = 1'b0;
        o_res       = '{byte_out: 8'd0, last: 1'b0, error_code: ERR_NONE};
        if (i_item.close_literal) begin
            n_mode  = M_NORMAL;
            n_digit = 4'd0;
            case (r_mode)
                M_DEAD: begin
                    // A dead literal ends silently; its error was already sent.
                end
                M_ESC, M_OCT1, M_OCT2, M_HEX1, M_HEX2: begin
                    o_res_valid = 1'b1;
                    o_res = '{byte_out: 8'd0, last: 1'b1, error_code: ERR_OPEN};
                end
                default: begin
                    o_res_valid = 1'b1;
                    o_res = '{byte_out: 8'd0, last: 1'b1, error_code: ERR_NONE};
                end
            endcase
        end else begin
            case (r_mode)
                M_DEAD: begin
                end
                M_ESC: begin
                    n_mode      = M_NORMAL;
                    o_res_valid = 1'b1;
                    case (i_item.ch)
                        "0":  begin
                            n_mode      = M_OCT1;
                            o_res_valid = 1'b0;
                        end
                        "x":  begin
                            n_mode      = M_HEX1;
                            o_res_valid = 1'b0;
                        end
                        "a":  o_res.byte_out = 8'd7;
                        "b":  o_res.byte_out = 8'd8;
                        "f":  o_res.byte_out = 8'd12;
                        "n":  o_res.byte_out = 8'd10;
                        "r":  o_res.byte_out = 8'd13;
                        "t":  o_res.byte_out = 8'd9;
                        "v":  o_res.byte_out = 8'd11;
                        "'":  o_res.byte_out = 8'd39;
                        "\"": o_res.byte_out = 8'd34;
                        "\\": o_res.byte_out = 8'd92;
                        "?":  o_res.byte_out = 8'd63;
                        default: begin
                            n_mode  = M_DEAD;
                            n_digit = 4'd0;
                            o_res   = '{byte_out: 8'd0, last: 1'b1, error_code: ERR_UNKNOWN};
                        end
                    endcase
                end
                M_OCT1, M_OCT2: begin
                    o_res_valid = 1'b1;
                    if (!oct_d.ok) begin
                        n_mode  = M_DEAD;
                        n_digit = 4'd0;
                        o_res   = '{byte_out: 8'd0, last: 1'b1, error_code: ERR_BAD_OCT};
                    end else if (r_mode == M_OCT1) begin
                        n_mode      = M_OCT2;
                        n_digit     = oct_d.val;
                        o_res_valid = 1'b0;
                    end else begin
                        n_mode         = M_NORMAL;
                        n_digit        = 4'd0;
                        o_res.byte_out = {2'b00, r_digit[2:0], oct_d.val[2:0]};
                    end
                end
                M_HEX1, M_HEX2: begin
                    o_res_valid = 1'b1;
                    if (!hex_d.ok) begin
                        n_mode  = M_DEAD;
                        n_digit = 4'd0;
                        o_res   = '{byte_out: 8'd0, last: 1'b1, error_code: ERR_BAD_HEX};
                    end else if (r_mode == M_HEX1) begin
                        n_mode      = M_HEX2;
                        n_digit     = hex_d.val;
                        o_res_valid = 1'b0;
                    end else begin
                        n_mode         = M_NORMAL;
                        n_digit        = 4'd0;
                        o_res.byte_out = {r_digit, hex_d.val};
                    end
                end
                default: begin
                    // Plain character mode; an unused mode code behaves the same.
                    n_mode = M_NORMAL;
                    if (i_item.ch == "\\") begin
                        n_mode = M_ESC;
                    end else begin
                        o_res_valid    = 1'b1;
                        o_res.byte_out = i_item.ch;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_digit <= 4'd0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_digit <= n_digit;
        end
    end

endmodule

// File: rtl/sled_out_stage.sv
// Result register of the string literal escape decoder.
module sled_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  sled_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output sled_pkg::t_result o_res
);
    import sled_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held word is taken in this cycle.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res_valid;
        end
        if (o_free && i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/string_literal_escape_decoder.sv
// Top level of the string literal escape decoder.
//
//   Channel   Direction  tdata (low bit up)   tlast           tuser
//   s_axis    in         ch[7:0]              close_literal   -
//   m_axis    out        byte_out[7:0]        last            error_code[2:0]
//
// A word accepted on s_axis is registered in the input register, decoded from
// there once the result register is free, and its result (if any) is then
// registered in the output register. One word is accepted per cycle while
// m_axis keeps up; a stalled result blocks the decode step, and the input
// register then holds one more word. Reset is synchronous and active low; it
// empties both registers and puts the decoder in plain character mode.
`include "string_literal_escape_decoder_assert.svh"
module string_literal_escape_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // ch[7:0]
    input  logic       s_axis_tlast,   // close_literal
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // byte_out[7:0]
    output logic       m_axis_tlast,   // last
    output logic [2:0] m_axis_tuser    // error_code[2:0]
);
    import sled_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    fire;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item = '{ch: s_axis_tdata, close_literal: s_axis_tlast};

    // The held word is decoded in the cycle that the result register can take it.
    assign fire = held_valid && out_free;

    sled_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (out_free),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    sled_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sled_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (m_axis_tready),
        .o_free      (out_free),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res)
    );

    assign m_axis_tdata = out_res.byte_out;
    assign m_axis_tlast = out_res.last;
    assign m_axis_tuser = out_res.error_code;

    // Every error result ends the literal and carries a zero byte.
    `SLED_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser != ERR_NONE),
        m_axis_tlast && (m_axis_tdata == 8'd0), "error result without last or zero byte")
    // A clean end of literal is the zero terminator.
    `SLED_ASSERT_IMP(a_term_zero, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tlast && (m_axis_tuser == ERR_NONE),
        m_axis_tdata == 8'd0, "terminator byte is not zero")
    // Only the defined error codes appear.
    `SLED_ASSERT_IMP(a_err_range, i_clk, i_rst_n, m_axis_tvalid,
        (m_axis_tuser == ERR_NONE) || (m_axis_tuser == ERR_BAD_OCT) ||
        (m_axis_tuser == ERR_BAD_HEX) || (m_axis_tuser == ERR_UNKNOWN) ||
        (m_axis_tuser == ERR_OPEN), "undefined error code")
    // A word that cannot be decoded stays in the input register unchanged.
    `SLED_ASSERT_NXT(a_hold_input, i_clk, i_rst_n, held_valid && !out_free,
        held_valid && $stable(held_item), "held input word lost while blocked")
    // A decoded result shows on m_axis in the next cycle.
    `SLED_ASSERT_NXT(a_result_out, i_clk, i_rst_n, fire && res_valid,
        m_axis_tvalid, "decoded result did not reach the output")

endmodule
